// ----- rtl/core/cpl_pkg.sv -----
`default_nettype none
package cpl_pkg;

  localparam int CB = 32;
  localparam int FB = 16;
  localparam int MUL_CHUNK = 32;

  localparam int RW = CB + 1;
  localparam int DW = 2 * CB + 3;
  localparam int PW = 2 * DW + 1;
  localparam int NW = PW + FB;
  localparam int XW = PW + CB;
  localparam int TW = 2 * CB + 1 - FB;
  localparam int THR_SH = 4 * FB - 32;
  localparam int FMASK = (1 << FB) - 1;

  localparam int ST_DOT = 5;
  localparam int ST_DIFF = 10;
  localparam int ST_ABS = 11;
  localparam int ST_SEL = 12;
  localparam int ST_OVF = 13;
  localparam int ST_SAT = ST_OVF + CB + 1;
  localparam int ST_SHF = ST_SAT + 5;
  localparam int ST_PT = ST_SHF + 1;
  localparam int N_ST = ST_PT + 1;

  localparam logic signed [CB-1:0] C_MAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] C_MIN = {1'b1, {(CB-1){1'b0}}};

  typedef enum logic [1:0] {
    OC_GENERAL  = 2'd0,
    OC_PARALLEL = 2'd1,
    OC_DEGEN    = 2'd2,
    OC_SAT      = 2'd3
  } outcome_t;

  typedef struct packed {
    logic signed [CB-1:0] first_point_x;
    logic signed [CB-1:0] first_point_y;
    logic signed [CB-1:0] first_point_z;
    logic signed [CB-1:0] first_dir_x;
    logic signed [CB-1:0] first_dir_y;
    logic signed [CB-1:0] first_dir_z;
    logic signed [CB-1:0] second_point_x;
    logic signed [CB-1:0] second_point_y;
    logic signed [CB-1:0] second_point_z;
    logic signed [CB-1:0] second_dir_x;
    logic signed [CB-1:0] second_dir_y;
    logic signed [CB-1:0] second_dir_z;
  } in_t;

  typedef struct packed {
    logic signed [CB-1:0] first_param;
    logic signed [CB-1:0] second_param;
    logic signed [CB-1:0] near_first_x;
    logic signed [CB-1:0] near_first_y;
    logic signed [CB-1:0] near_first_z;
    logic signed [CB-1:0] near_second_x;
    logic signed [CB-1:0] near_second_y;
    logic signed [CB-1:0] near_second_z;
    outcome_t             outcome;
  } out_t;

endpackage
`default_nettype wire

// ----- rtl/core/cpl_mul.sv -----
`default_nettype none
module cpl_mul #(
  parameter int WA = 32,
  parameter int WB = 33
) (
  input  logic                     clk,
  input  logic [3:0]               en,
  input  logic signed [WA-1:0]     a,
  input  logic signed [WB-1:0]     b,
  output logic signed [WA+WB-1:0]  p
);
  import cpl_pkg::*;

  localparam int NA = (WA + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int NB = (WB + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int MA = NA * MUL_CHUNK;
  localparam int MB = NB * MUL_CHUNK;
  localparam int SW = MA + MB;
  localparam int PD = WA + WB;

  logic [WA-1:0] ma;
  logic [WB-1:0] mb;
  logic [MA-1:0] ma_x;
  logic [MB-1:0] mb_x;
  logic [2*MUL_CHUNK-1:0] pp_r [NA][NB];
  logic [SW-1:0] row [NA];
  logic [SW-1:0] row_r [NA];
  logic [SW-1:0] tot;
  logic [PD-1:0] mag_r;
  logic sg0_r, sg1_r, sg2_r;
  logic signed [PD-1:0] p_r;

  // sign-magnitude split so partial products are plain unsigned chunks
  assign ma = a[WA-1] ? $unsigned(-a) : $unsigned(a);
  assign mb = b[WB-1] ? $unsigned(-b) : $unsigned(b);
  assign ma_x = MA'(ma);
  assign mb_x = MB'(mb);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_r[i][j] <= ma_x[i*MUL_CHUNK +: MUL_CHUNK] * mb_x[j*MUL_CHUNK +: MUL_CHUNK];
        end
      end
      sg0_r <= a[WA-1] ^ b[WB-1];
    end
  end

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row[i] = row[i] + (SW'(pp_r[i][j]) << (j * MUL_CHUNK));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      row_r <= row;
      sg1_r <= sg0_r;
    end
  end

  always_comb begin
    tot = '0;
    for (int i = 0; i < NA; i++) begin
      tot = tot + (row_r[i] << (i * MUL_CHUNK));
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      mag_r <= PD'(tot);
      sg2_r <= sg1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      p_r <= sg2_r ? -$signed(mag_r) : $signed(mag_r);
    end
  end

  assign p = p_r;

endmodule
`default_nettype wire

// ----- rtl/core/closest_points_between_lines.sv -----
`default_nettype none
// Closest points between two 3D lines, signed Q16.16 in and out. Fully pipelined: one
// line pair is taken every cycle while out_ready does not hold the pipeline (53 register
// stages with 32-bit coordinates, 21 stages plus one restoring divide stage per quotient
// bit). The depth is set by the two side-by-side quotient dividers (s and t); the 4-stage
// chunked multipliers for the dot products, the cross terms and the final points make up
// most of the rest. Each stage moves on when it is empty or its successor moves, so
// bubbles are squeezed out and input is still accepted while a finished result waits at
// the output, as long as some stage is empty. parallel_threshold is written through the
// cfg port, always ready; write it only while the pipeline is empty. outcome: general,
// parallel, zero divisor (s = t = 0) or saturated.
module closest_points_between_lines (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  cpl_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output cpl_pkg::out_t  out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [31:0]    cfg_data
);
  import cpl_pkg::*;

  // divider control that rides along with the remainders
  typedef struct packed {
    outcome_t mode;
    logic     zero;
    logic     neg_s;
    logic     neg_t;
    logic     ovf_s;
    logic     ovf_t;
  } dctl_t;

  typedef struct packed {
    logic signed [CB-1:0] sv;
    logic signed [CB-1:0] tv;
    logic                 sat;
    outcome_t             mode;
  } res_t;

  typedef struct packed {
    logic signed [CB-1:0] v;
    logic                 big;
  } sq_t;

  // clamp a sign-magnitude quotient into the coordinate range
  function automatic sq_t sat_q(input logic [CB-1:0] q, input logic neg, input logic ovf);
    sq_t res;
    logic [CB-1:0] half;
    half = CB'(1) << (CB - 1);
    res.big = ovf || (neg ? (q > half) : (q > (half - CB'(1))));
    if (res.big) begin
      res.v = neg ? C_MIN : C_MAX;
    end else begin
      res.v = neg ? -$signed(q) : $signed(q);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- stage control
  logic [N_ST:0]   en;
  logic [N_ST-1:0] v_r;
  logic [31:0]     thr_r;

  assign en[N_ST] = out_ready;
  genvar gi;
  generate
    for (gi = 0; gi < N_ST; gi++) begin : g_en
      assign en[gi] = !v_r[gi] || en[gi+1];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < N_ST; i++) begin
        if (en[i]) begin
          v_r[i] <= (i == 0) ? in_valid : v_r[i-1];
        end
      end
    end
  end

  assign in_ready = en[0];
  assign out_valid = v_r[ST_PT];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 32'd1;
    end else if (cfg_valid) begin
      thr_r <= cfg_data;
    end
  end

  // ---------------------------------------------------------------- input beat
  in_t ip_r [ST_SHF+1];
  logic signed [RW-1:0] r_r [3];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ip_r[0] <= in_data;
      r_r[0] <= RW'(in_data.first_point_x) - RW'(in_data.second_point_x);
      r_r[1] <= RW'(in_data.first_point_y) - RW'(in_data.second_point_y);
      r_r[2] <= RW'(in_data.first_point_z) - RW'(in_data.second_point_z);
    end
  end

  // line data is needed again for the points at the very end
  generate
    for (gi = 1; gi <= ST_SHF; gi++) begin : g_ip
      always_ff @(posedge clk) begin
        if (en[gi]) begin
          ip_r[gi] <= ip_r[gi-1];
        end
      end
    end
  endgenerate

  // ---------------------------------------------------------------- dot products
  logic signed [CB-1:0] d1v [3];
  logic signed [CB-1:0] d2v [3];
  logic signed [CB+RW-1:0] pa [3];
  logic signed [CB+RW-1:0] pb [3];
  logic signed [CB+RW-1:0] pc [3];
  logic signed [CB+RW-1:0] pd [3];
  logic signed [CB+RW-1:0] pe [3];

  assign d1v[0] = ip_r[0].first_dir_x;
  assign d1v[1] = ip_r[0].first_dir_y;
  assign d1v[2] = ip_r[0].first_dir_z;
  assign d2v[0] = ip_r[0].second_dir_x;
  assign d2v[1] = ip_r[0].second_dir_y;
  assign d2v[2] = ip_r[0].second_dir_z;

  generate
    for (gi = 0; gi < 3; gi++) begin : g_dot
      cpl_mul #(.WA(CB), .WB(RW)) u_a (
        .clk(clk), .en(en[1 +: 4]), .a(d1v[gi]), .b(RW'(d1v[gi])), .p(pa[gi]));
      cpl_mul #(.WA(CB), .WB(RW)) u_b (
        .clk(clk), .en(en[1 +: 4]), .a(d1v[gi]), .b(RW'(d2v[gi])), .p(pb[gi]));
      cpl_mul #(.WA(CB), .WB(RW)) u_c (
        .clk(clk), .en(en[1 +: 4]), .a(d2v[gi]), .b(RW'(d2v[gi])), .p(pc[gi]));
      cpl_mul #(.WA(CB), .WB(RW)) u_d (
        .clk(clk), .en(en[1 +: 4]), .a(d1v[gi]), .b(r_r[gi]), .p(pd[gi]));
      cpl_mul #(.WA(CB), .WB(RW)) u_e (
        .clk(clk), .en(en[1 +: 4]), .a(d2v[gi]), .b(r_r[gi]), .p(pe[gi]));
    end
  endgenerate

  logic signed [DW-1:0] a_r, b_r, c_r, d_r, e_r;

  always_ff @(posedge clk) begin
    if (en[ST_DOT]) begin
      a_r <= DW'(pa[0]) + DW'(pa[1]) + DW'(pa[2]);
      b_r <= DW'(pb[0]) + DW'(pb[1]) + DW'(pb[2]);
      c_r <= DW'(pc[0]) + DW'(pc[1]) + DW'(pc[2]);
      d_r <= DW'(pd[0]) + DW'(pd[1]) + DW'(pd[2]);
      e_r <= DW'(pe[0]) + DW'(pe[1]) + DW'(pe[2]);
    end
  end

  // ---------------------------------------------------------------- cross terms
  logic signed [2*DW-1:0] m_ac, m_bb, m_be, m_cd, m_ae, m_bd;

  cpl_mul #(.WA(DW), .WB(DW)) u_ac (
    .clk(clk), .en(en[ST_DOT+1 +: 4]), .a(a_r), .b(c_r), .p(m_ac));
  cpl_mul #(.WA(DW), .WB(DW)) u_bb (
    .clk(clk), .en(en[ST_DOT+1 +: 4]), .a(b_r), .b(b_r), .p(m_bb));
  cpl_mul #(.WA(DW), .WB(DW)) u_be (
    .clk(clk), .en(en[ST_DOT+1 +: 4]), .a(b_r), .b(e_r), .p(m_be));
  cpl_mul #(.WA(DW), .WB(DW)) u_cd (
    .clk(clk), .en(en[ST_DOT+1 +: 4]), .a(c_r), .b(d_r), .p(m_cd));
  cpl_mul #(.WA(DW), .WB(DW)) u_ae (
    .clk(clk), .en(en[ST_DOT+1 +: 4]), .a(a_r), .b(e_r), .p(m_ae));
  cpl_mul #(.WA(DW), .WB(DW)) u_bd (
    .clk(clk), .en(en[ST_DOT+1 +: 4]), .a(b_r), .b(d_r), .p(m_bd));

  // parallel fallback: t = d/b when b > c (b nonnegative), else e/c
  logic signed [DW-1:0] pn_r [ST_DOT+1:ST_DIFF];
  logic signed [DW-1:0] pdv_r [ST_DOT+1:ST_DIFF];
  logic b_gt_c;

  assign b_gt_c = !b_r[DW-1] && (b_r > c_r);

  always_ff @(posedge clk) begin
    if (en[ST_DOT+1]) begin
      pn_r[ST_DOT+1] <= b_gt_c ? d_r : e_r;
      pdv_r[ST_DOT+1] <= b_gt_c ? b_r : c_r;
    end
  end

  generate
    for (gi = ST_DOT + 2; gi <= ST_DIFF; gi++) begin : g_pn
      always_ff @(posedge clk) begin
        if (en[gi]) begin
          pn_r[gi] <= pn_r[gi-1];
          pdv_r[gi] <= pdv_r[gi-1];
        end
      end
    end
  endgenerate

  logic signed [PW-1:0] den_r, ns_r, nt_r;

  always_ff @(posedge clk) begin
    if (en[ST_DIFF]) begin
      den_r <= PW'(m_ac) - PW'(m_bb);
      ns_r <= PW'(m_be) - PW'(m_cd);
      nt_r <= PW'(m_ae) - PW'(m_bd);
    end
  end

  // ---------------------------------------------------------------- magnitudes
  logic [PW-1:0] aden_r, nsm_r, ntm_r, pnm_r, pdm_r;
  logic dneg_r, dzero_r, nsn_r, ntn_r, pnn_r, pdn_r;
  logic [DW-1:0] pn_mag, pd_mag;

  assign pn_mag = pn_r[ST_DIFF][DW-1] ? $unsigned(-pn_r[ST_DIFF]) : $unsigned(pn_r[ST_DIFF]);
  assign pd_mag = pdv_r[ST_DIFF][DW-1] ? $unsigned(-pdv_r[ST_DIFF])
                                       : $unsigned(pdv_r[ST_DIFF]);

  always_ff @(posedge clk) begin
    if (en[ST_ABS]) begin
      aden_r <= den_r[PW-1] ? $unsigned(-den_r) : $unsigned(den_r);
      dneg_r <= den_r[PW-1];
      dzero_r <= (den_r == '0);
      nsm_r <= ns_r[PW-1] ? $unsigned(-ns_r) : $unsigned(ns_r);
      nsn_r <= ns_r[PW-1];
      ntm_r <= nt_r[PW-1] ? $unsigned(-nt_r) : $unsigned(nt_r);
      ntn_r <= nt_r[PW-1];
      pnm_r <= PW'(pn_mag);
      pnn_r <= pn_r[ST_DIFF][DW-1];
      pdm_r <= PW'(pd_mag);
      pdn_r <= pdv_r[ST_DIFF][DW-1];
    end
  end

  // ---------------------------------------------------------------- case select
  logic [PW-1:0] sel_d_r;
  logic [NW-1:0] sel_ns_r, sel_nt_r;
  dctl_t sel_ctl_r;
  logic is_par;

  assign is_par = aden_r < (PW'(thr_r) << THR_SH);

  always_ff @(posedge clk) begin
    if (en[ST_SEL]) begin
      sel_ctl_r.ovf_s <= 1'b0;
      sel_ctl_r.ovf_t <= 1'b0;
      if (is_par) begin
        sel_d_r <= pdm_r;
        sel_ns_r <= '0;
        sel_nt_r <= NW'(pnm_r) << FB;
        sel_ctl_r.neg_s <= 1'b0;
        sel_ctl_r.neg_t <= pnn_r ^ pdn_r;
        sel_ctl_r.zero <= (pdm_r == '0);
        sel_ctl_r.mode <= (pdm_r == '0) ? OC_DEGEN : OC_PARALLEL;
      end else begin
        sel_d_r <= aden_r;
        sel_ns_r <= NW'(nsm_r) << FB;
        sel_nt_r <= NW'(ntm_r) << FB;
        sel_ctl_r.neg_s <= nsn_r ^ dneg_r;
        sel_ctl_r.neg_t <= ntn_r ^ dneg_r;
        // a zero denominator only gets here with a zero threshold
        sel_ctl_r.zero <= dzero_r;
        sel_ctl_r.mode <= dzero_r ? OC_DEGEN : OC_GENERAL;
      end
    end
  end

  // ---------------------------------------------------------------- dividers
  logic [PW-1:0] dv_r [CB+1];
  logic [NW-1:0] rs_r [CB+1];
  logic [NW-1:0] rt_r [CB+1];
  logic [CB-1:0] qs_r [CB+1];
  logic [CB-1:0] qt_r [CB+1];
  dctl_t ctl_r [CB+1];
  dctl_t ctl_in;

  // quotient must fit in CB bits, anything at or above d << CB saturates
  always_comb begin
    ctl_in = sel_ctl_r;
    ctl_in.ovf_s = XW'(sel_ns_r) >= (XW'(sel_d_r) << CB);
    ctl_in.ovf_t = XW'(sel_nt_r) >= (XW'(sel_d_r) << CB);
  end

  always_ff @(posedge clk) begin
    if (en[ST_OVF]) begin
      dv_r[0] <= sel_d_r;
      rs_r[0] <= sel_ns_r;
      rt_r[0] <= sel_nt_r;
      qs_r[0] <= '0;
      qt_r[0] <= '0;
      ctl_r[0] <= ctl_in;
    end
  end

  generate
    for (gi = 1; gi <= CB; gi++) begin : g_div
      localparam int BITP = CB - gi;
      logic [XW-1:0] dsh;
      logic ge_s, ge_t;
      assign dsh = XW'(dv_r[gi-1]) << BITP;
      assign ge_s = XW'(rs_r[gi-1]) >= dsh;
      assign ge_t = XW'(rt_r[gi-1]) >= dsh;
      always_ff @(posedge clk) begin
        if (en[ST_OVF+gi]) begin
          dv_r[gi] <= dv_r[gi-1];
          rs_r[gi] <= ge_s ? NW'(XW'(rs_r[gi-1]) - dsh) : rs_r[gi-1];
          rt_r[gi] <= ge_t ? NW'(XW'(rt_r[gi-1]) - dsh) : rt_r[gi-1];
          qs_r[gi] <= {qs_r[gi-1][CB-2:0], ge_s};
          qt_r[gi] <= {qt_r[gi-1][CB-2:0], ge_t};
          ctl_r[gi] <= ctl_r[gi-1];
        end
      end
    end
  endgenerate

  // ---------------------------------------------------------------- clamp s, t
  res_t res_r [ST_SAT:ST_SHF];
  sq_t qs_sat, qt_sat;

  assign qs_sat = sat_q(qs_r[CB], ctl_r[CB].neg_s, ctl_r[CB].ovf_s);
  assign qt_sat = sat_q(qt_r[CB], ctl_r[CB].neg_t, ctl_r[CB].ovf_t);

  always_ff @(posedge clk) begin
    if (en[ST_SAT]) begin
      res_r[ST_SAT].mode <= ctl_r[CB].mode;
      if (ctl_r[CB].zero) begin
        res_r[ST_SAT].sv <= '0;
        res_r[ST_SAT].tv <= '0;
        res_r[ST_SAT].sat <= 1'b0;
      end else begin
        res_r[ST_SAT].sv <= qs_sat.v;
        res_r[ST_SAT].tv <= qt_sat.v;
        res_r[ST_SAT].sat <= qs_sat.big || qt_sat.big;
      end
    end
  end

  generate
    for (gi = ST_SAT + 1; gi <= ST_SHF; gi++) begin : g_res
      always_ff @(posedge clk) begin
        if (en[gi]) begin
          res_r[gi] <= res_r[gi-1];
        end
      end
    end
  endgenerate

  // ---------------------------------------------------------------- points
  logic signed [CB-1:0] dd [6];
  logic signed [CB-1:0] pp [6];
  logic signed [2*CB-1:0] sd [6];

  assign dd[0] = ip_r[ST_SAT].first_dir_x;
  assign dd[1] = ip_r[ST_SAT].first_dir_y;
  assign dd[2] = ip_r[ST_SAT].first_dir_z;
  assign dd[3] = ip_r[ST_SAT].second_dir_x;
  assign dd[4] = ip_r[ST_SAT].second_dir_y;
  assign dd[5] = ip_r[ST_SAT].second_dir_z;
  assign pp[0] = ip_r[ST_SHF].first_point_x;
  assign pp[1] = ip_r[ST_SHF].first_point_y;
  assign pp[2] = ip_r[ST_SHF].first_point_z;
  assign pp[3] = ip_r[ST_SHF].second_point_x;
  assign pp[4] = ip_r[ST_SHF].second_point_y;
  assign pp[5] = ip_r[ST_SHF].second_point_z;

  logic signed [TW-1:0] term_r [6];
  logic signed [TW:0] psum [6];
  logic [5:0] psat;
  logic signed [CB-1:0] pclamp [6];

  generate
    for (gi = 0; gi < 6; gi++) begin : g_pt
      logic signed [2*CB:0] biased;
      cpl_mul #(.WA(CB), .WB(CB)) u_m (
        .clk(clk), .en(en[ST_SAT+1 +: 4]),
        .a((gi < 3) ? res_r[ST_SAT].sv : res_r[ST_SAT].tv), .b(dd[gi]), .p(sd[gi]));
      // bias negatives so the arithmetic shift truncates toward zero
      assign biased = (2*CB+1)'(sd[gi])
                    + (sd[gi][2*CB-1] ? (2*CB+1)'(FMASK) : (2*CB+1)'(0));
      always_ff @(posedge clk) begin
        if (en[ST_SHF]) begin
          term_r[gi] <= TW'(biased >>> FB);
        end
      end
      assign psum[gi] = (TW+1)'(term_r[gi]) + (TW+1)'(pp[gi]);
      assign psat[gi] = (psum[gi] > (TW+1)'(C_MAX)) || (psum[gi] < (TW+1)'(C_MIN));
      assign pclamp[gi] = (psum[gi] > (TW+1)'(C_MAX)) ? C_MAX :
                          (psum[gi] < (TW+1)'(C_MIN)) ? C_MIN : CB'(psum[gi]);
    end
  endgenerate

  // ---------------------------------------------------------------- output beat
  out_t out_r;
  out_t out_nxt;
  logic any_sat;

  assign any_sat = res_r[ST_SHF].sat || (psat != '0);

  always_comb begin
    out_nxt.first_param = res_r[ST_SHF].sv;
    out_nxt.second_param = res_r[ST_SHF].tv;
    out_nxt.near_first_x = pclamp[0];
    out_nxt.near_first_y = pclamp[1];
    out_nxt.near_first_z = pclamp[2];
    out_nxt.near_second_x = pclamp[3];
    out_nxt.near_second_y = pclamp[4];
    out_nxt.near_second_z = pclamp[5];
    // clamping wins over general and parallel, never over zero divisor
    if (any_sat && res_r[ST_SHF].mode != OC_DEGEN) begin
      out_nxt.outcome = OC_SAT;
    end else begin
      out_nxt.outcome = res_r[ST_SHF].mode;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_PT]) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

  // ---------------------------------------------------------------- checks
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.outcome == OC_DEGEN |->
      out_data.first_param == '0 && out_data.second_param == '0)
    else $error("zero divisor beat with nonzero parameters");

  a_par_s_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.outcome == OC_PARALLEL |-> out_data.first_param == '0)
    else $error("parallel beat with nonzero s");

  a_in_taken: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v_r[0])
    else $error("accepted beat not held in first stage");

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
module testbench;
  import cpl_pkg::*;

  typedef logic signed [255:0] big_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_valid = 1'b0;
  logic         in_ready;
  in_t          in_data = '0;
  logic         out_valid;
  logic         out_ready = 1'b0;
  out_t         out_data;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [31:0]  cfg_data = '0;

  // line pairs waiting to be driven, expected answers waiting for a result beat
  in_t          pending_pairs[$];
  out_t         expected_points[$];
  logic [31:0]  threshold_shadow = 32'd1;
  int           mismatches = 0;
  bit           in_fire = 1'b0;
  bit           cfg_fire = 1'b0;
  bit           quiet = 1'b0;
  bit           hold_req = 1'b0;
  bit           hold_done = 1'b0;
  int           hold_left = 0;

  closest_points_between_lines DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // generous cap: well beyond the slowest legal run
  initial begin
    #8000000;
    $display("== FAIL ==");
    $finish;
  end

  // clamp to the signed coordinate range, flag when clamped
  function automatic logic signed [CB-1:0] clamp_coord(big_t v, inout bit clamped);
    big_t hi, lo;
    hi = big_t'(C_MAX);
    lo = big_t'(C_MIN);
    if (v > hi) begin
      clamped = 1'b1;
      return C_MAX;
    end
    if (v < lo) begin
      clamped = 1'b1;
      return C_MIN;
    end
    return v[CB-1:0];
  endfunction

  // exact closest-point solution, everything in wide signed integers
  function automatic out_t closest_points(in_t x, logic [31:0] thr_reg);
    big_t  p1[3], d1[3], p2[3], d2[3], r[3];
    big_t  a, b, c, d, e, den, aden, thr, num, dv, s, t, prod;
    logic signed [CB-1:0] sv, tv;
    bit    clamped;
    outcome_t oc;
    out_t  res;
    p1[0] = big_t'(x.first_point_x);  p1[1] = big_t'(x.first_point_y);
    p1[2] = big_t'(x.first_point_z);
    d1[0] = big_t'(x.first_dir_x);    d1[1] = big_t'(x.first_dir_y);
    d1[2] = big_t'(x.first_dir_z);
    p2[0] = big_t'(x.second_point_x); p2[1] = big_t'(x.second_point_y);
    p2[2] = big_t'(x.second_point_z);
    d2[0] = big_t'(x.second_dir_x);   d2[1] = big_t'(x.second_dir_y);
    d2[2] = big_t'(x.second_dir_z);
    for (int k = 0; k < 3; k++) r[k] = p1[k] - p2[k];
    a = d1[0]*d1[0] + d1[1]*d1[1] + d1[2]*d1[2];
    b = d1[0]*d2[0] + d1[1]*d2[1] + d1[2]*d2[2];
    c = d2[0]*d2[0] + d2[1]*d2[1] + d2[2]*d2[2];
    d = d1[0]*r[0] + d1[1]*r[1] + d1[2]*r[2];
    e = d2[0]*r[0] + d2[1]*r[1] + d2[2]*r[2];
    den = a*c - b*b;
    aden = (den < 0) ? -den : den;
    // threshold has 32 fraction bits, denominator has 4*FB
    thr = '0;
    thr[THR_SH +: 32] = thr_reg;
    sv = '0;
    tv = '0;
    clamped = 1'b0;
    if (aden < thr) begin
      oc = OC_PARALLEL;
      if (b > c) begin
        num = d;
        dv = b;
      end else begin
        num = e;
        dv = c;
      end
      if (dv == 0) oc = OC_DEGEN;
      else begin
        t = (num * (big_t'(1) <<< FB)) / dv;
        tv = clamp_coord(t, clamped);
      end
    end else if (den == 0) begin
      oc = OC_DEGEN;
    end else begin
      oc = OC_GENERAL;
      s = ((b*e - c*d) * (big_t'(1) <<< FB)) / den;
      t = ((a*e - b*d) * (big_t'(1) <<< FB)) / den;
      sv = clamp_coord(s, clamped);
      tv = clamp_coord(t, clamped);
    end
    res.first_param = sv;
    res.second_param = tv;
    // scaled offsets truncate toward zero, then add to the base point
    prod = big_t'(sv) * d1[0]; res.near_first_x = clamp_coord(p1[0] + prod / 65536, clamped);
    prod = big_t'(sv) * d1[1]; res.near_first_y = clamp_coord(p1[1] + prod / 65536, clamped);
    prod = big_t'(sv) * d1[2]; res.near_first_z = clamp_coord(p1[2] + prod / 65536, clamped);
    prod = big_t'(tv) * d2[0]; res.near_second_x = clamp_coord(p2[0] + prod / 65536, clamped);
    prod = big_t'(tv) * d2[1]; res.near_second_y = clamp_coord(p2[1] + prod / 65536, clamped);
    prod = big_t'(tv) * d2[2]; res.near_second_z = clamp_coord(p2[2] + prod / 65536, clamped);
    if (clamped && oc != OC_DEGEN) oc = OC_SAT;
    res.outcome = oc;
    return res;
  endfunction

  // handshakes are sampled at the rising edge only
  always @(posedge clk) begin
    in_fire <= in_valid && in_ready;
    cfg_fire <= cfg_valid && cfg_ready;
    if (cfg_valid && cfg_ready) threshold_shadow <= cfg_data;
    if (in_valid && in_ready)
      expected_points = {expected_points, closest_points(in_data, threshold_shadow)};
  end

  // result checker
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %h", out_data);
      end else begin
        want = expected_points.pop_front();
        if (want.first_param !== out_data.first_param ||
            want.second_param !== out_data.second_param ||
            want.near_first_x !== out_data.near_first_x ||
            want.near_first_y !== out_data.near_first_y ||
            want.near_first_z !== out_data.near_first_z ||
            want.near_second_x !== out_data.near_second_x ||
            want.near_second_y !== out_data.near_second_y ||
            want.near_second_z !== out_data.near_second_z ||
            want.outcome !== out_data.outcome) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch\n  exp %h\n  got %h", want, out_data);
        end
      end
    end
  end

  // sender: random idle bursts separated by busy stretches
  int send_idle = 0;
  int send_busy = 0;
  always @(negedge clk) begin
    if (!in_valid || in_fire) begin
      if (send_idle > 0 && !quiet) begin
        send_idle <= send_idle - 1;
        in_valid <= 1'b0;
      end else if (pending_pairs.size() != 0) begin
        in_data <= pending_pairs.pop_front();
        in_valid <= 1'b1;
        if (send_busy > 0) send_busy <= send_busy - 1;
        else if ($urandom_range(0, 3) == 0) begin
          send_idle <= $urandom_range(1, 18);
          send_busy <= $urandom_range(0, 60);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold, counted in its own process
  always @(negedge clk) begin
    if (hold_req && !hold_done && hold_left == 0) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver stalls
  int recv_idle = 0;
  int recv_busy = 0;
  always @(negedge clk) begin
    if (hold_left > 0 || (hold_req && !hold_done)) begin
      out_ready <= 1'b0;
    end else if (quiet) begin
      out_ready <= 1'b1;
    end else if (recv_idle > 0) begin
      recv_idle <= recv_idle - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (recv_busy > 0) recv_busy <= recv_busy - 1;
      else if ($urandom_range(0, 3) == 0) begin
        recv_idle <= $urandom_range(1, 18);
        recv_busy <= $urandom_range(0, 60);
      end
    end
  end

  function automatic logic signed [CB-1:0] rand_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      2: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
      default: return $urandom_range(0, 1) ? C_MAX : C_MIN;
    endcase
  endfunction

  // random pair: mostly moderate geometry, some parallel, some wild
  function automatic in_t rand_pair();
    in_t  x;
    int   mode, shape;
    mode = $urandom_range(0, 9);
    mode = (mode < 2) ? 0 : (mode < 7) ? 1 : (mode < 9) ? 2 : 3;
    x.first_point_x = rand_coord(mode);  x.first_point_y = rand_coord(mode);
    x.first_point_z = rand_coord(mode);
    x.first_dir_x = rand_coord(mode);    x.first_dir_y = rand_coord(mode);
    x.first_dir_z = rand_coord(mode);
    x.second_point_x = rand_coord(mode); x.second_point_y = rand_coord(mode);
    x.second_point_z = rand_coord(mode);
    x.second_dir_x = rand_coord(mode);   x.second_dir_y = rand_coord(mode);
    x.second_dir_z = rand_coord(mode);
    shape = $urandom_range(0, 11);
    case (shape)
      0: begin
        // same direction
        x.second_dir_x = x.first_dir_x; x.second_dir_y = x.first_dir_y;
        x.second_dir_z = x.first_dir_z;
      end
      1: begin
        // opposite direction
        x.second_dir_x = -x.first_dir_x; x.second_dir_y = -x.first_dir_y;
        x.second_dir_z = -x.first_dir_z;
      end
      2: begin
        // first direction twice the second, so b > c
        x.second_dir_x = x.first_dir_x >>> 1; x.second_dir_y = x.first_dir_y >>> 1;
        x.second_dir_z = x.first_dir_z >>> 1;
        x.first_dir_x = x.second_dir_x <<< 1; x.first_dir_y = x.second_dir_y <<< 1;
        x.first_dir_z = x.second_dir_z <<< 1;
      end
      3: begin
        // nearly parallel
        x.second_dir_x = x.first_dir_x + $signed($urandom_range(0, 2)) - 1;
        x.second_dir_y = x.first_dir_y;
        x.second_dir_z = x.first_dir_z;
      end
      4: begin
        x.second_dir_x = '0; x.second_dir_y = '0; x.second_dir_z = '0;
      end
      default: ;
    endcase
    return x;
  endfunction

  task automatic push_pair(logic signed [CB-1:0] p1x, logic signed [CB-1:0] p1y,
                           logic signed [CB-1:0] p1z, logic signed [CB-1:0] d1x,
                           logic signed [CB-1:0] d1y, logic signed [CB-1:0] d1z,
                           logic signed [CB-1:0] p2x, logic signed [CB-1:0] p2y,
                           logic signed [CB-1:0] p2z, logic signed [CB-1:0] d2x,
                           logic signed [CB-1:0] d2y, logic signed [CB-1:0] d2z);
    in_t x;
    x = {p1x, p1y, p1z, d1x, d1y, d1z, p2x, p2y, p2z, d2x, d2y, d2z};
    pending_pairs = {pending_pairs, x};
  endtask

  // checked at the rising edge, where the sender's queue and valid are settled
  task automatic drain();
    while (pending_pairs.size() != 0 || in_valid || expected_points.size() != 0)
      @(posedge clk);
    // nothing can be in flight without an expectation, but allow the pipe to settle
    repeat (60) @(negedge clk);
  endtask

  task automatic write_threshold(logic [31:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    while (!cfg_fire) @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  localparam logic signed [CB-1:0] ONE = 32'sh0001_0000;

  initial begin
    logic [31:0] thresholds[6];
    thresholds = '{32'd1, 32'd0, 32'hFFFF_FFFF, 32'h0000_1000, 32'h8000_0000, 32'd1};
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed beats at the reset threshold
    push_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);                  // all zero: degenerate
    push_pair(0, 0, 0, ONE, 0, 0, 0, ONE, ONE, 0, ONE, 0);          // skew axes
    push_pair(ONE, 2*ONE, -ONE, ONE, 0, 0, 0, 0, 0, 0, 0, ONE);
    push_pair(0, 0, 0, 2*ONE, 0, 0, 0, ONE, 0, ONE, 0, 0);          // parallel, b > c
    push_pair(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 2*ONE, 0, 0);          // parallel, b <= c
    push_pair(0, 0, 0, ONE, 0, 0, 0, ONE, 0, -ONE, 0, 0);           // antiparallel
    push_pair(5*ONE, 0, 0, ONE, 0, 0, 0, 0, 0, 0, 0, 0);            // zero second dir
    push_pair(0, 0, 0, 0, 0, 0, ONE, ONE, ONE, ONE, 0, 0);          // zero first dir
    push_pair(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
              C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
    push_pair(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
              C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
    push_pair(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, 1,
              C_MIN, C_MAX, C_MIN, 1, C_MIN, C_MAX);
    push_pair(C_MAX, 0, 0, 1, 0, 0, C_MIN, 0, 0, 0, 1, 0);          // huge s, clamps
    push_pair(0, 0, 0, 1, 0, 0, 0, 0, 0, 1, 1, 0);                  // tiny directions
    push_pair(-ONE, -ONE, -ONE, -1, -1, -1, 0, 0, 0, 1, -1, 0);
    push_pair(0, C_MAX, 0, ONE, 0, 0, 0, 0, 0, 0, 1, 0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_threshold(thresholds[ph]);
      if (ph == 5) quiet = 1'b1;
      if (ph == 1) hold_req = 1'b1;
      for (int n = 0; n < 205; n++) begin
        pending_pairs = {pending_pairs, rand_pair()};
        // sender pause until everything has come back
        if (ph == 2 && n == 100) drain();
      end
      drain();
    end

    repeat (80) @(negedge clk);
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
